// File: hw/rtl/rscd_pkg.sv
package rscd_pkg;

   // Ring size and the fixed width of every mask field
   localparam int CELLS   = 32;
   localparam int FIELD_W = 32;

   typedef logic [FIELD_W-1:0] mask_type;

   typedef enum logic {
      KIND_ROUND = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type kind;
      mask_type syndrome_bits;
      mask_type noise_left_mask;
      mask_type noise_right_mask;
   } req_type;

   typedef struct packed {
      mask_type flip_mask;
      mask_type left_signals;
      mask_type right_signals;
   } rsp_type;

endpackage

// File: hw/rtl/rscd_req_if.sv
interface rscd_req_if;
   import rscd_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/rscd_rsp_if.sv
interface rscd_rsp_if;
   import rscd_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ring_signal_ca_decoder_step_top.sv
// One round of a cellular-automaton decoder for a repetition code on a ring of
// rscd_pkg::CELLS cells. Each req item is either a decoding round (syndrome plus
// two noise masks) or a clear that zeroes every cell's left/right signal state.
// Every item produces exactly one rsp item: the XOR-combined qubit flip mask and
// the new left and right signals (zero for a clear). All cells update in parallel,
// so one item is taken per clock unless rsp stalls it; its result is registered
// and appears in the cycle after acceptance. The output register is the only stage,
// and a new item is taken in the same cycle the waiting result is taken. Cells past
// bit 31 see zero syndrome and noise, and output bits at or above CELLS read zero.
module ring_signal_ca_decoder_step_top (
   input  logic clock,
   input  logic reset,
   rscd_req_if.sink   req,
   rscd_rsp_if.source rsp
);
   import rscd_pkg::*;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [CELLS-1:0] left_ff, left_in;
   logic [CELLS-1:0] right_ff, right_in;

   logic             req_acc;
   logic [CELLS-1:0] syn_c, nzl_c, nzr_c;
   logic [CELLS-1:0] hit_pv, hit_own;
   logic [CELLS-1:0] new_left, new_right, flip_c;
   mask_type         flip_rpt, left_rpt, right_rpt;
   mask_type         left_state_rpt, right_state_rpt;

   // Take a new item whenever the output register is empty or being drained
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_acc   = req.valid && req.ready;

   genvar gi;
   generate
      for (gi = 0; gi < CELLS; gi++) begin : g_cell
         localparam int PP = (gi + 2 * CELLS - 2) % CELLS;
         localparam int PV = (gi + CELLS - 1) % CELLS;
         localparam int NX = (gi + 1) % CELLS;
         logic sl, sc, sr, li, ri;

         if (gi < FIELD_W) begin : g_in
            assign syn_c[gi] = req.data.syndrome_bits[gi];
            assign nzl_c[gi] = req.data.noise_left_mask[gi];
            assign nzr_c[gi] = req.data.noise_right_mask[gi];
         end else begin : g_zero
            assign syn_c[gi] = 1'b0;
            assign nzl_c[gi] = 1'b0;
            assign nzr_c[gi] = 1'b0;
         end

         assign sl = syn_c[PP];
         assign sc = syn_c[PV];
         assign sr = syn_c[gi];
         // An empty neighbor passes a syndrome-launched signal
         assign li = left_ff[NX]  || (!left_ff[NX] && !right_ff[NX] && sr);
         assign ri = right_ff[PV] || (!left_ff[PV] && !right_ff[PV] && sl);

         assign hit_pv[gi]  = (sl && sc) || (!sl && sc && !sr && !li && ri);
         assign hit_own[gi] = !(sl && sc) && !sl && sc && !sr && li && !ri;

         assign new_left[gi]  = li ^ nzl_c[gi];
         assign new_right[gi] = ri ^ nzr_c[gi];
         // Qubit gi is hit by its own cell and by the next cell's backward target
         assign flip_c[gi] = hit_pv[NX] ^ hit_own[gi];
      end

      for (gi = 0; gi < FIELD_W; gi++) begin : g_rpt
         if (gi < CELLS) begin : g_live
            assign flip_rpt[gi]        = flip_c[gi];
            assign left_rpt[gi]        = new_left[gi];
            assign right_rpt[gi]       = new_right[gi];
            assign left_state_rpt[gi]  = left_ff[gi];
            assign right_state_rpt[gi] = right_ff[gi];
         end else begin : g_dead
            assign flip_rpt[gi]        = 1'b0;
            assign left_rpt[gi]        = 1'b0;
            assign right_rpt[gi]       = 1'b0;
            assign left_state_rpt[gi]  = 1'b0;
            assign right_state_rpt[gi] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      if (req_acc) begin
         rsp_valid_in = 1'b1;
         if (req.data.kind == KIND_CLEAR) begin
            left_in     = '0;
            right_in    = '0;
            rsp_data_in = '0;
         end else begin
            left_in                   = new_left;
            right_in                  = new_right;
            rsp_data_in.flip_mask     = flip_rpt;
            rsp_data_in.left_signals  = left_rpt;
            rsp_data_in.right_signals = right_rpt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         right_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   a_clear_zeroes_state: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req.data.kind == KIND_CLEAR) |=> (left_ff == '0 && right_ff == '0))
      else $error("clear item left nonzero cell state");

   a_clear_no_flips: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req.data.kind == KIND_CLEAR) |=> (rsp.data.flip_mask == '0))
      else $error("clear item reported flips");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp.data.left_signals == left_state_rpt &&
                        rsp.data.right_signals == right_state_rpt))
      else $error("reported signals differ from stored cell state");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("item taken while result is stalled");

endmodule
